>>> design/rth_pkg.sv
`timescale 1ns / 1ps
package rth_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // arctangent table in degrees, 24 fraction bits
  localparam int      TBL_BITS    = 24;
  localparam longint  SQRT3_Q24   = 64'sd29058991;
  localparam longint  RAD2DEG_Q24 = 64'sd961263669;
  localparam longint  ATAN_Q24 [11] = '{
    64'sd754974720, 64'sd445687602, 64'sd235489088, 64'sd119537938, 64'sd60000934,
    64'sd30029717, 64'sd15018523, 64'sd7509720, 64'sd3754917, 64'sd1877466,
    64'sd938734
  };

  // divider geometry for saturation
  localparam int REM_W = 19;
  localparam int DEN_W = 11;
  localparam int Q_W   = 8;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] intensity;
  } hsi_out_t;

  // round half up, for positive constants
  function automatic longint rsh_round(longint v, int s);
    longint r;
    r = v;
    if (s > 0) begin
      r = (v + (longint'(1) <<< (s - 1))) >>> s;
    end
    return r;
  endfunction

  function automatic longint atan_qf(int i, int f);
    longint base;
    base = (i <= 10) ? ATAN_Q24[i] : rsh_round(RAD2DEG_Q24, i);
    return rsh_round(base, TBL_BITS - f);
  endfunction

endpackage

>>> design/rth_prep.sv
`timescale 1ns / 1ps
module rth_prep #(
  parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF,
  parameter int W         = FRAC_BITS + 12,
  parameter int ZW        = FRAC_BITS + 10
) (
  input  rth_pkg::pix_in_t               pix_i,
  output logic signed [W-1:0]            x_o,
  output logic signed [W-1:0]            y_o,
  output logic signed [ZW-1:0]           z_o,
  output logic                           axis_o,
  output logic                           gray_o,
  output logic                           mirror_o,
  output logic                           black_o,
  output logic [rth_pkg::REM_W-1:0]      rem_o,
  output logic [rth_pkg::DEN_W-1:0]      den_o,
  output logic [7:0]                     inten_o
);
  import rth_pkg::*;

  localparam logic [FRAC_BITS:0] S3Q =
    (FRAC_BITS + 1)'(rsh_round(SQRT3_Q24, TBL_BITS - FRAC_BITS));
  localparam logic signed [ZW-1:0] ONE = ZW'(1) <<< FRAC_BITS;

  logic signed [10:0]          diff;
  logic [7:0]                  d;
  logic signed [W-1:0]         xr;
  logic signed [W-1:0]         yr;
  logic [9:0]                  sum;
  logic [7:0]                  mn;
  logic [9:0]                  spread;
  logic [10:0]                 iv;
  logic [24:0]                 iprod;

  always_comb begin
    diff = $signed({2'b00, pix_i.red, 1'b0}) - $signed({3'b000, pix_i.green})
         - $signed({3'b000, pix_i.blue});
    d    = (pix_i.green > pix_i.blue) ? pix_i.green - pix_i.blue
                                      : pix_i.blue - pix_i.green;
    xr   = W'(diff) <<< FRAC_BITS;
    yr   = $signed(W'(d * S3Q));

    axis_o   = (d == 8'd0);
    gray_o   = axis_o && (diff == 11'sd0);
    mirror_o = pix_i.blue > pix_i.green;

    x_o = xr;
    y_o = yr;
    z_o = '0;
    if (axis_o) begin
      z_o = (xr > 0) ? '0 : ONE * ZW'(180);
    end else if (xr < 0) begin
      // turn by -90 degrees so the vector sits in the right half plane
      x_o = yr;
      y_o = -xr;
      z_o = ONE * ZW'(90);
    end

    sum = 10'(pix_i.red) + 10'(pix_i.green) + 10'(pix_i.blue);
    mn  = pix_i.red;
    if (pix_i.green < mn) mn = pix_i.green;
    if (pix_i.blue < mn)  mn = pix_i.blue;
    spread  = sum - 10'(3 * 10'(mn));
    black_o = (sum == 10'd0);
    rem_o   = REM_W'(spread) * REM_W'(510) + REM_W'(sum);
    den_o   = {sum, 1'b0};

    // floor((2*sum+3)/6) by reciprocal, exact below 1536
    iv      = {sum, 1'b0} + 11'd3;
    iprod   = 25'(iv) * 25'd10923;
    inten_o = iprod[23:16];
  end

endmodule

>>> design/rth_cordic_step.sv
`timescale 1ns / 1ps
module rth_cordic_step #(
  parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF,
  parameter int STEP      = 0,
  parameter int W         = FRAC_BITS + 12,
  parameter int ZW        = FRAC_BITS + 10
) (
  input  logic                  bypass_i,
  input  logic signed [W-1:0]   x_i,
  input  logic signed [W-1:0]   y_i,
  input  logic signed [ZW-1:0]  z_i,
  output logic signed [W-1:0]   x_o,
  output logic signed [W-1:0]   y_o,
  output logic signed [ZW-1:0]  z_o
);
  import rth_pkg::*;

  localparam logic signed [ZW-1:0] ANG = ZW'(atan_qf(STEP, FRAC_BITS));

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;

  always_comb begin
    // shifts truncate toward zero
    xs = x_i[W-1] ? -((-x_i) >>> STEP) : (x_i >>> STEP);
    ys = y_i[W-1] ? -((-y_i) >>> STEP) : (y_i >>> STEP);
    x_o = x_i;
    y_o = y_i;
    z_o = z_i;
    if (!bypass_i) begin
      if (y_i > 0) begin
        x_o = x_i + ys;
        y_o = y_i - xs;
        z_o = z_i + ANG;
      end else begin
        x_o = x_i - ys;
        y_o = y_i + xs;
        z_o = z_i - ANG;
      end
    end
  end

endmodule

>>> design/rth_div_step.sv
`timescale 1ns / 1ps
module rth_div_step #(
  parameter int SHIFT = 0
) (
  input  logic [rth_pkg::REM_W-1:0] rem_i,
  input  logic [rth_pkg::DEN_W-1:0] den_i,
  input  logic [rth_pkg::Q_W-1:0]   q_i,
  output logic [rth_pkg::REM_W-1:0] rem_o,
  output logic [rth_pkg::Q_W-1:0]   q_o
);
  import rth_pkg::*;

  logic [REM_W-1:0] t;

  always_comb begin
    t     = REM_W'(den_i) << SHIFT;
    rem_o = rem_i;
    q_o   = q_i;
    if (rem_i >= t) begin
      rem_o    = rem_i - t;
      q_o[SHIFT] = 1'b1;
    end
  end

endmodule

>>> design/rth_post.sv
`timescale 1ns / 1ps
module rth_post #(
  parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF,
  parameter int ZW        = FRAC_BITS + 10
) (
  input  logic signed [ZW-1:0]   z_i,
  input  logic                   gray_i,
  input  logic                   mirror_i,
  input  logic                   black_i,
  input  logic [rth_pkg::Q_W-1:0] q_i,
  input  logic [7:0]             inten_i,
  output rth_pkg::hsi_out_t      res_o
);
  import rth_pkg::*;

  localparam logic signed [ZW-1:0] ONE  = ZW'(1) <<< FRAC_BITS;
  localparam logic signed [ZW-1:0] Z180 = ONE * ZW'(180);

  logic signed [ZW-1:0] zc;
  logic signed [ZW-1:0] h;
  logic signed [ZW-1:0] hr;

  always_comb begin
    zc = z_i;
    if (z_i < 0) zc = '0;
    if (z_i > Z180) zc = Z180;
    h  = mirror_i ? (ONE * ZW'(360) - zc) : zc;
    hr = (h + ONE) >>> (FRAC_BITS + 1);
    res_o.hue        = gray_i ? 8'd0 : hr[7:0];
    res_o.saturation = black_i ? 8'd0 : q_i;
    res_o.intensity  = inten_i;
  end

endmodule

>>> design/rgb_to_hsi_pixel.sv
`timescale 1ns / 1ps
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+-----------------------------
// pixel   | in        | in_valid_i / in_ready_o | in_data_i  (blue,green,red)
// result  | out       | out_valid_o/ out_ready_i| out_data_o (hue,sat,intens)
//
// one request per clock sustained while the output is not stalled
// the depth is set by the hue CORDIC: one micro-rotation per stage after the prep stage
// reset clears all stage valid bits; data registers are not reset
// a stage holds when the next one is full and stalled, bubbles are squeezed out
module rgb_to_hsi_pixel #(
  parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rth_pkg::pix_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rth_pkg::hsi_out_t out_data_o
);
  import rth_pkg::*;

  localparam int W  = FRAC_BITS + 12;  // cordic x/y, magnitude below 1024 units
  localparam int ZW = FRAC_BITS + 10;  // angle accumulator in degrees
  localparam int NS = FRAC_BITS + 2;   // prep stage plus one stage per rotation

  typedef struct packed {
    logic signed [W-1:0]  x;
    logic signed [W-1:0]  y;
    logic signed [ZW-1:0] z;
    logic                 axis;
    logic                 gray;
    logic                 mirror;
    logic                 black;
    logic [REM_W-1:0]     rem;
    logic [DEN_W-1:0]     den;
    logic [Q_W-1:0]       q;
    logic [7:0]           inten;
  } stg_t;

  stg_t     st_q   [NS];
  stg_t     st_d   [NS];
  logic     v_q    [NS];
  logic     rdy    [NS];
  logic     out_v_q;
  hsi_out_t out_q;
  hsi_out_t out_d;

  // ready chain: a stage moves when it is empty or its successor moves
  logic out_rdy;
  assign out_rdy = !out_v_q || out_ready_i;

  // walk from the output back so each stage sees its successor's fresh ready
  always_comb begin
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !v_q[s] || ((s == NS - 1) ? out_rdy : rdy[(s + 1) % NS]);
    end
  end

  assign in_ready_o = rdy[0];

  // stage 0: vector setup, saturation numerator, intensity
  rth_prep #(.FRAC_BITS(FRAC_BITS), .W(W), .ZW(ZW)) u_prep (
    .pix_i    (in_data_i),
    .x_o      (st_d[0].x),
    .y_o      (st_d[0].y),
    .z_o      (st_d[0].z),
    .axis_o   (st_d[0].axis),
    .gray_o   (st_d[0].gray),
    .mirror_o (st_d[0].mirror),
    .black_o  (st_d[0].black),
    .rem_o    (st_d[0].rem),
    .den_o    (st_d[0].den),
    .inten_o  (st_d[0].inten)
  );
  assign st_d[0].q = '0;

  // stages 1..NS-1: one rotation each, first eight also retire a quotient bit
  for (genvar s = 1; s < NS; s++) begin : g_stage
    rth_cordic_step #(.FRAC_BITS(FRAC_BITS), .STEP(s - 1), .W(W), .ZW(ZW)) u_rot (
      .bypass_i (st_q[s-1].axis),
      .x_i      (st_q[s-1].x),
      .y_i      (st_q[s-1].y),
      .z_i      (st_q[s-1].z),
      .x_o      (st_d[s].x),
      .y_o      (st_d[s].y),
      .z_o      (st_d[s].z)
    );
    assign st_d[s].axis   = st_q[s-1].axis;
    assign st_d[s].gray   = st_q[s-1].gray;
    assign st_d[s].mirror = st_q[s-1].mirror;
    assign st_d[s].black  = st_q[s-1].black;
    assign st_d[s].den    = st_q[s-1].den;
    assign st_d[s].inten  = st_q[s-1].inten;
    if (s <= Q_W) begin : g_div
      rth_div_step #(.SHIFT(Q_W - s)) u_div (
        .rem_i (st_q[s-1].rem),
        .den_i (st_q[s-1].den),
        .q_i   (st_q[s-1].q),
        .rem_o (st_d[s].rem),
        .q_o   (st_d[s].q)
      );
    end else begin : g_nodiv
      assign st_d[s].rem = st_q[s-1].rem;
      assign st_d[s].q   = st_q[s-1].q;
    end
  end

  // final: clamp, mirror and round the hue, mask hue of gray and saturation of black
  rth_post #(.FRAC_BITS(FRAC_BITS), .ZW(ZW)) u_post (
    .z_i      (st_q[NS-1].z),
    .gray_i   (st_q[NS-1].gray),
    .mirror_i (st_q[NS-1].mirror),
    .black_i  (st_q[NS-1].black),
    .q_i      (st_q[NS-1].q),
    .inten_i  (st_q[NS-1].inten),
    .res_o    (out_d)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (rdy[s]) begin
          v_q[s] <= (s == 0) ? in_valid_i : v_q[(s + NS - 1) % NS];
        end
      end
      if (out_rdy) begin
        out_v_q <= v_q[NS-1];
      end
    end
  end

  // data registers load only when a request moves in
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NS; s++) begin
      if (rdy[s] && ((s == 0) ? in_valid_i : v_q[(s + NS - 1) % NS])) begin
        st_q[s] <= st_d[s];
      end
    end
    if (out_rdy && v_q[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // hue is degrees halved, never beyond 180
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.hue <= 8'd180)
    else $error("hue out of range");

  // an empty output register means the whole chain can move
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // an accepted pixel lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted pixel lost at entry");

  // black pixels carry zero saturation
  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_rdy && v_q[NS-1] && st_q[NS-1].black |=> out_data_o.saturation == 8'd0)
    else $error("black pixel with nonzero saturation");
`endif

endmodule

>>> sim/rgb_to_hsi_pixel_tb.sv
`timescale 1ns / 1ps
module rgb_to_hsi_pixel_tb;
  import rth_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int N_RANDOM = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = FB + 3 + 10;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  pix_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  hsi_out_t out_data_o;

  rgb_to_hsi_pixel #(.FRAC_BITS(FB)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  hsi_out_t hsi_pending_q[$];
  int       mismatch_cnt;
  int       idle_cycles;
  int       in_idle_pct;
  int       out_idle_pct;

  // rounding right shift, two's complement wrap like the 64-bit unsigned add
  function automatic longint shr_round(longint v, int s);
    if (s == 0) return v;
    return longint'((64'(v) + (64'd1 << (s - 1))) >> s);
  endfunction

  // arithmetic shift that truncates toward zero
  function automatic longint shr_to_zero(longint v, int s);
    if (v < 0) return -longint'(64'(-v) >> s);
    return longint'(64'(v) >> s);
  endfunction

  // hue by cordic vectoring in degrees, FB fraction bits
  function automatic logic [7:0] calc_hue(longint r, longint g, longint b);
    longint unit, d, x, y, z, h, xs, ys, tmp, step;
    unit = longint'(1) << FB;
    d = (g > b) ? g - b : b - g;
    x = (2 * r - g - b) * unit;
    y = d * shr_round(SQRT3_Q24, TBL_BITS - FB);
    z = 0;
    if (r == g && g == b) return 8'd0;
    if (d == 0) begin
      z = (x > 0) ? 0 : 180 * unit;
    end else begin
      if (x < 0) begin
        tmp = x;
        x = y;
        y = -tmp;
        z = 90 * unit;
      end
      for (int i = 0; i <= FB; i++) begin
        xs = shr_to_zero(x, i);
        ys = shr_to_zero(y, i);
        step = (i <= 10) ? ATAN_Q24[i] : shr_round(RAD2DEG_Q24, i);
        step = shr_round(step, TBL_BITS - FB);
        if (y > 0) begin
          x += ys;
          y -= xs;
          z += step;
        end else begin
          x -= ys;
          y += xs;
          z -= step;
        end
      end
    end
    if (z < 0) z = 0;
    if (z > 180 * unit) z = 180 * unit;
    h = (b > g) ? 360 * unit - z : z;
    h = longint'((64'(h) + 64'(unit)) >> (FB + 1));
    if (h > 255) h = 255;
    return h[7:0];
  endfunction

  function automatic hsi_out_t calc_hsi(pix_in_t p);
    hsi_out_t res;
    longint r, g, b, sum, mn, sat, inten;
    r = p.red;
    g = p.green;
    b = p.blue;
    sum = r + g + b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sat = 0;
    if (sum > 0) begin
      sat = (510 * (sum - 3 * mn) + sum) / (2 * sum);
      if (sat > 255) sat = 255;
    end
    inten = (2 * sum + 3) / 6;
    if (inten > 255) inten = 255;
    res.hue = calc_hue(r, g, b);
    res.saturation = sat[7:0];
    res.intensity = inten[7:0];
    return res;
  endfunction

  // directed rows: {blue, green, red}, with fixed expectation where obvious
  typedef struct {
    pix_in_t  pix;
    bit       fixed;
    hsi_out_t res;
  } pix_row_t;

  pix_row_t pix_rows[] = '{
    '{'{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},         // black
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd255}}, // white
    '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd0, 8'd0, 8'd128}}, // mid gray
    '{'{8'd1, 8'd1, 8'd1}, 1'b1, '{8'd0, 8'd0, 8'd1}},
    '{'{8'd0, 8'd0, 8'd255}, 1'b1, '{8'd0, 8'd255, 8'd85}},    // pure red
    '{'{8'd10, 8'd10, 8'd200}, 1'b0, '{8'd0, 8'd0, 8'd0}},     // red axis, r > g
    '{'{8'd200, 8'd200, 8'd10}, 1'b0, '{8'd0, 8'd0, 8'd0}},    // red axis, r < g
    '{'{8'd255, 8'd255, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd255, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},       // pure green
    '{'{8'd255, 8'd0, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},       // pure blue
    '{'{8'd0, 8'd255, 8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}},     // yellow
    '{'{8'd255, 8'd0, 8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}},     // magenta
    '{'{8'd255, 8'd254, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},     // b just above g
    '{'{8'd254, 8'd255, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd1, 8'd0, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd0, 8'd1, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd170, 8'd85, 8'd85}, 1'b0, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd128, 8'd64, 8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}}
  };

  // result side: random stall and compare against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    hsi_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (hsi_pending_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result %h", out_data_o);
        end else begin
          want = hsi_pending_q.pop_front();
          if (out_data_o.hue !== want.hue || out_data_o.saturation !== want.saturation ||
              out_data_o.intensity !== want.intensity) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp h=%0d s=%0d i=%0d got h=%0d s=%0d i=%0d",
                       want.hue, want.saturation, want.intensity,
                       out_data_o.hue, out_data_o.saturation, out_data_o.intensity);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("rgb_to_hsi_pixel_tb: done, errors");
        $finish;
      end
    end
  end

  // push one pixel with random pre-gap; prediction made at acceptance
  task automatic send_pixel(input pix_in_t p, input bit fixed, input hsi_out_t res);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    hsi_pending_q.push_back(fixed ? res : calc_hsi(p));
  endtask

  task automatic random_pixel(output pix_in_t p);
    p = pix_in_t'(24'($urandom));
    case ($urandom_range(4))
      0: p.green = p.blue;                  // on the red axis
      1: begin p.green = p.red; p.blue = p.red; end
      2: p.blue = 8'(p.green + $urandom_range(1) * (($urandom_range(1) != 0) ? 1 : -1));
      default: ;
    endcase
  endtask

  initial begin
    pix_in_t px;
    hsi_out_t none;
    mismatch_cnt = 0;
    idle_cycles  = 0;
    in_idle_pct  = 37;
    out_idle_pct = 75;
    none = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (pix_rows[k]) send_pixel(pix_rows[k].pix, pix_rows[k].fixed, pix_rows[k].res);

    // three idling phases: receiver heavy, sender heavy, none
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 37 : (ph == 1) ? 75 : 0;
      out_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 37 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        random_pixel(px);
        send_pixel(px, 1'b0, none);
      end
    end
    in_valid_i <= 1'b0;

    while (hsi_pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("rgb_to_hsi_pixel_tb: done, clean");
    end else begin
      $display("rgb_to_hsi_pixel_tb: done, errors");
    end
    $finish;
  end

endmodule
